[design/assert_macros.svh]
// Assertion macros used by the top-level converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CHECK_PROP(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
`define CHECK_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define CHECK_PROP(label, prop)
`define CHECK_NEVER(label, expr)
`endif
`endif

[design/sidasc_pkg.sv]
// Constants and types for the signed integer to decimal text converter.
package sidasc_pkg;
    localparam int VALUE_W        = 32;
    localparam int DIGIT_W        = 4;
    localparam int NUM_DIGITS     = 10;
    localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
    localparam int BITS_PER_STAGE = 8;
    localparam int NUM_STAGES     = VALUE_W / BITS_PER_STAGE;
    localparam int IDX_W          = $clog2(NUM_DIGITS);
    localparam int CHAR_W         = 8;
    localparam int COUNT_W        = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Work carried down the double-dabble pipeline.
    typedef struct packed {
        logic               neg;
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] mag;
    } dab_t;
endpackage

[design/sidasc_dab_stage.sv]
// One registered pipeline stage of the binary to BCD (double-dabble) conversion.
module sidasc_dab_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    input  sidasc_pkg::dab_t   up_data,
    output logic               up_ready,
    output logic               dn_valid,
    output sidasc_pkg::dab_t   dn_data,
    input  logic               dn_ready
);
    import sidasc_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    dab_t               data_reg;
    dab_t               data_next;
    logic [BCD_W-1:0]   bcd_w;
    logic [VALUE_W-1:0] mag_w;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    // Each step corrects every digit above four, then shifts in the next magnitude bit.
    always_comb
    begin
        bcd_w = up_data.bcd;
        mag_w = up_data.mag;
        for (int s = 0; s < BITS_PER_STAGE; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (bcd_w[d*DIGIT_W +: DIGIT_W] >= 4'd5)
                begin
                    bcd_w[d*DIGIT_W +: DIGIT_W] = bcd_w[d*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            bcd_w = {bcd_w[BCD_W-2:0], mag_w[VALUE_W-1]};
            mag_w = {mag_w[VALUE_W-2:0], 1'b0};
        end
        data_next.neg = up_data.neg;
        data_next.bcd = bcd_w;
        data_next.mag = mag_w;
    end

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end
endmodule

[design/signed_int_to_decimal_ascii.sv]
// Signed 32-bit integer to decimal ASCII text, one character per output transfer.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  value
//   output   out        out_valid/out_stall  char_code, last_char, char_count
//
// A value passes a negate stage and four double-dabble stages of eight bits each,
// and is registered once more in the serializer before its first character appears.
// The serializer then sends one character per cycle while out_stall is low, so 1 to 11
// characters per value, and that serializer sets the sustained rate; the pipeline behind it
// holds up to five further values. Reset empties every stage. A stall on the
// output holds the current character and backs up the pipeline without loss.
`include "assert_macros.svh"

module signed_int_to_decimal_ascii (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [sidasc_pkg::VALUE_W-1:0]  value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic        [sidasc_pkg::CHAR_W-1:0]   char_code,
    output logic                                   last_char,
    output logic        [sidasc_pkg::COUNT_W-1:0]  char_count
);
    import sidasc_pkg::*;

    // Stage zero: sign and magnitude.
    logic               s0_valid_reg;
    logic               s0_valid_next;
    dab_t               s0_data_reg;
    logic               s0_ready;

    logic               stg_valid [NUM_STAGES+1];
    dab_t               stg_data  [NUM_STAGES+1];
    logic               stg_ready [NUM_STAGES+1];

    // Character serializer.
    logic               ser_valid_reg;
    logic               ser_valid_next;
    logic               sign_pend_reg;
    logic               sign_pend_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;
    logic [DIGIT_W-1:0] digits_reg [NUM_DIGITS];

    logic               ser_take;
    logic               ser_load;
    logic [IDX_W-1:0]   top_idx;
    logic [DIGIT_W-1:0] cur_digit;

    assign s0_ready = !s0_valid_reg || stg_ready[0];
    assign in_stall = !s0_ready;

    always_comb
    begin
        s0_valid_next = s0_ready ? in_valid : s0_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
        end
    end

    // The most negative value negates to itself, which as unsigned is its true magnitude.
    always_ff @(posedge clk)
    begin
        if (s0_ready && in_valid)
        begin
            s0_data_reg.neg <= value[VALUE_W-1];
            s0_data_reg.bcd <= '0;
            s0_data_reg.mag <= value[VALUE_W-1] ? (~value + 1'b1) : value;
        end
    end

    assign stg_valid[0] = s0_valid_reg;
    assign stg_data[0]  = s0_data_reg;

    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_dab
        sidasc_dab_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[g]),
            .up_data  (stg_data[g]),
            .up_ready (stg_ready[g]),
            .dn_valid (stg_valid[g+1]),
            .dn_data  (stg_data[g+1]),
            .dn_ready (stg_ready[g+1])
        );
    end

    // Highest nonzero digit; zero keeps digit zero so it prints as one '0'.
    always_comb
    begin
        top_idx = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (stg_data[NUM_STAGES].bcd[d*DIGIT_W +: DIGIT_W] != '0)
            begin
                top_idx = IDX_W'(d);
            end
        end
    end

    assign cur_digit  = digits_reg[idx_reg];
    assign out_valid  = ser_valid_reg;
    assign char_code  = sign_pend_reg ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, cur_digit});
    assign last_char  = !sign_pend_reg && (idx_reg == '0);
    assign char_count = last_char ? total_reg : '0;

    assign ser_take = ser_valid_reg && !out_stall;
    assign ser_load = !ser_valid_reg || (ser_take && last_char);
    assign stg_ready[NUM_STAGES] = ser_load;

    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        sign_pend_next = sign_pend_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        if (ser_load)
        begin
            ser_valid_next = stg_valid[NUM_STAGES];
            if (stg_valid[NUM_STAGES])
            begin
                sign_pend_next = stg_data[NUM_STAGES].neg;
                idx_next       = top_idx;
                total_next     = COUNT_W'(top_idx) + COUNT_W'(1)
                                 + {{(COUNT_W-1){1'b0}}, stg_data[NUM_STAGES].neg};
            end
        end
        else if (ser_take)
        begin
            if (sign_pend_reg)
            begin
                sign_pend_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            sign_pend_reg <= 1'b0;
            idx_reg       <= '0;
            total_reg     <= '0;
        end
        else
        begin
            ser_valid_reg <= ser_valid_next;
            sign_pend_reg <= sign_pend_next;
            idx_reg       <= idx_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_load && stg_valid[NUM_STAGES])
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                digits_reg[d] <= stg_data[NUM_STAGES].bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // A number that is not finished keeps the output busy with its next character.
    `CHECK_PROP(a_more_chars, (ser_take && !last_char) |=> out_valid)
    // The sign is followed by a digit of the same number.
    `CHECK_PROP(a_digit_after_sign, (ser_take && sign_pend_reg) |=> (out_valid && !sign_pend_reg))
    // The digit pointer never leaves the digit store while a number is out.
    `CHECK_NEVER(a_idx_range, ser_valid_reg && (idx_reg > IDX_W'(NUM_DIGITS - 1)))
    // The count held for the last character is never short of the digits still pointed at.
    `CHECK_NEVER(a_count_short, ser_valid_reg && (total_reg <= COUNT_W'(idx_reg)))
endmodule

[tb/signed_int_to_decimal_ascii_tb.sv]
// Self-checking testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_tb;
    import sidasc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 24;
    localparam int RANDOM_ITEMS = 32;

    typedef struct packed {
        logic [CHAR_W-1:0]  code;
        logic               last;
        logic [COUNT_W-1:0] count;
    } ascii_char_t;

    // Predicts the character stream of each accepted value and checks the
    // characters leaving the block against it in order.
    class char_scoreboard;
        ascii_char_t expected_chars[$];
        int          errors;
        int          values_seen;
        int          chars_checked;

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        function int pending();
            return expected_chars.size();
        endfunction

        function void note_input(logic [VALUE_W-1:0] raw);
            logic               neg;
            logic [VALUE_W-1:0] mag;
            logic [DIGIT_W-1:0] digits [NUM_DIGITS];
            int                 nd;
            int                 total;
            ascii_char_t        c;
            neg = raw[VALUE_W-1];
            // The most negative value negates to itself, which read as
            // unsigned is exactly its magnitude.
            mag = neg ? (32'd0 - raw) : raw;
            nd  = 0;
            do
            begin
                digits[nd] = 4'(mag % 32'd10);
                mag        = mag / 32'd10;
                nd++;
            end
            while (mag != 0 && nd < NUM_DIGITS);
            total = nd + (neg ? 1 : 0);
            values_seen++;
            if (neg)
            begin
                c.code  = CHAR_MINUS;
                c.last  = 1'b0;
                c.count = '0;
                expected_chars.push_back(c);
            end
            for (int i = nd; i > 0; i--)
            begin
                c.code  = CHAR_ZERO + CHAR_W'(digits[i-1]);
                c.last  = (i == 1);
                c.count = (i == 1) ? COUNT_W'(total) : '0;
                expected_chars.push_back(c);
            end
        endfunction

        task check_result(logic [CHAR_W-1:0] code, logic last, logic [COUNT_W-1:0] count);
            ascii_char_t want;
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                report($sformatf("unexpected character 0x%02h last=%0b count=%0d",
                                 code, last, count));
                return;
            end
            want = expected_chars.pop_front();
            if (code !== want.code)
                report($sformatf("char_code 0x%02h, expected 0x%02h", code, want.code));
            if (last !== want.last)
                report($sformatf("last_char %0b, expected %0b", last, want.last));
            if (count !== want.count)
                report($sformatf("char_count %0d, expected %0d", count, want.count));
        endtask
    endclass

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       in_valid   = 1'b0;
    logic                       in_stall;
    logic signed [VALUE_W-1:0]  value      = '0;
    logic                       out_valid;
    logic                       out_stall  = 1'b0;
    logic        [CHAR_W-1:0]   char_code;
    logic                       last_char;
    logic        [COUNT_W-1:0]  char_count;

    int             send_idle_pct = 0;
    int             stall_pct     = 0;
    int             cycle_count   = 0;
    char_scoreboard board;

    signed_int_to_decimal_ascii dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .char_code  (char_code),
        .last_char  (last_char),
        .char_count (char_count)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(char_code, last_char, char_count);

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d characters outstanding",
                 cycle_count, board.pending());
        $display("CHECK FAILED");
        $finish;
    end

    // Presents one value and holds it until the block takes the transfer.
    task send_value(input logic [VALUE_W-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(v);
    endtask

    // Mostly values of a random digit count and sign, plus raw 32-bit patterns.
    task send_random(input int count);
        int unsigned n;
        longint      lo;
        longint      hi;
        longint      mag;
        repeat (count)
        begin
            if ($urandom_range(3) == 0)
                send_value($urandom);
            else
            begin
                n  = $urandom_range(NUM_DIGITS, 1);
                hi = 1;
                repeat (n)
                    hi = hi * 10;
                lo = (n == 1) ? 0 : hi / 10;
                hi = hi - 1;
                if (hi > 64'd2147483647)
                    hi = 64'd2147483647;
                mag = lo + longint'($urandom_range(32'(hi - lo), 0));
                send_value($urandom_range(1) ? VALUE_W'(-mag) : VALUE_W'(mag));
            end
        end
    endtask

    task wait_drained(input int settle);
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (settle)
            @(posedge clk);
    endtask

    int directed_values [22] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, -1000, 12345, -678901,
        9999999, 10000000, -123456789, 999999999, 1000000000, -1000000000,
        1999999999, 2147483647, 32'h8000_0000, -2147483647
    };
    int idle_phases  [4] = '{0, 67, 0, 16};
    int stall_phases [4] = '{0, 0, 67, 16};

    initial
    begin
        board = new();
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_values[i])
            send_value(directed_values[i]);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_phases[p];
            stall_pct     = stall_phases[p];
            send_random(RANDOM_ITEMS);
            // Let the pipeline empty completely before the pacing changes.
            wait_drained(0);
        end

        stall_pct = 0;
        wait_drained(SETTLE);
        $display("Converted %0d values into %0d characters under four pacing mixes,",
                 board.values_seen, board.chars_checked);
        $display("covering every digit count, both signs and both 32-bit extremes.");
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
